### hw/rtl/spn_dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn_dec_pkg
// Shared widths, table types, reset values and register indexes for the
// toy substitution-permutation byte decipher
// ----------------------------------------------------------------------------
package spn_dec_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned NibbleW  = 4;
  localparam int unsigned SboxN    = 16;
  localparam int unsigned PosW     = 3;
  localparam int unsigned PermN    = 8;
  localparam int unsigned Rounds   = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;

  typedef logic [ByteW-1:0]               byte_t;
  typedef logic [KeyW-1:0]                key_t;
  typedef logic [SboxN-1:0][NibbleW-1:0]  sbox_t;
  typedef logic [PermN-1:0][PosW-1:0]     perm_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRoundKey    = 2'd0,
    CfgSboxInverse = 2'd1,
    CfgPermInverse = 2'd2
  } cfg_idx_e;

  localparam key_t  KeyRst  = 32'h0000_0000;
  localparam sbox_t SboxRst = 64'hFEDC_BA98_7654_3210;
  localparam perm_t PermRst = 24'hFA_C688;

endpackage

### hw/rtl/spn_dec_cipher_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn_dec_cipher_if
// Valid/ready channel carrying one ciphertext byte per transaction
// ----------------------------------------------------------------------------
interface spn_dec_cipher_if;
  import spn_dec_pkg::*;

  logic  valid;
  logic  ready;
  byte_t cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink   (input valid, input cipher_byte, output ready);
endinterface

### hw/rtl/spn_dec_plain_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn_dec_plain_if
// Valid/ready channel carrying one plaintext byte per transaction
// ----------------------------------------------------------------------------
interface spn_dec_plain_if;
  import spn_dec_pkg::*;

  logic  valid;
  logic  ready;
  byte_t plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

### hw/rtl/spn_dec_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn_dec_round
// One inverse round: bit gather by the inverse permutation, inverse S-box on
// both nibbles, then XOR with the round key byte
// ----------------------------------------------------------------------------
module spn_dec_round (
  input  spn_dec_pkg::byte_t data_i,
  input  spn_dec_pkg::sbox_t sbox_i,
  input  spn_dec_pkg::perm_t perm_i,
  input  spn_dec_pkg::byte_t key_i,
  output spn_dec_pkg::byte_t data_o
);
  import spn_dec_pkg::*;

  byte_t perm_byte;
  byte_t subs_byte;

  // result bit 7-i takes source bit 7-entry[i]
  always_comb begin
    for (int unsigned i = 0; i < PermN; i++) begin
      perm_byte[PosW'(PermN - 1 - i)] = data_i[~perm_i[i]];
    end
  end

  assign subs_byte = {sbox_i[perm_byte[ByteW-1:NibbleW]], sbox_i[perm_byte[NibbleW-1:0]]};
  assign data_o    = subs_byte ^ key_i;

endmodule

### hw/rtl/toy_spn_byte_decipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_spn_byte_decipher_top
// Toy 8-bit SPN decipher: key whitening then three inverse rounds per byte
// ----------------------------------------------------------------------------
// Takes one ciphertext byte per cycle and returns one plaintext byte per
// cycle while the output is not stalled. The byte is captured in an input
// register; whitening and the three inverse rounds are one combinational
// pass into the output register, which sets the clock period. The user must
// write key, inverse S-box and inverse permutation through the configuration
// port while no transaction is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module toy_spn_byte_decipher_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spn_dec_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [spn_dec_pkg::CfgDataW-1:0]    cfg_data_i,
  spn_dec_cipher_if.sink                      cipher_i,
  spn_dec_plain_if.source                     plain_o
);
  import spn_dec_pkg::*;

  key_t  round_key_q;
  sbox_t sbox_q;
  perm_t perm_q;

  logic  in_valid_q;
  byte_t in_byte_q;
  logic  out_valid_q;
  byte_t out_byte_q;

  logic  out_load;
  logic  in_load;

  byte_t round_data [Rounds+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_key_q <= KeyRst;
      sbox_q      <= SboxRst;
      perm_q      <= PermRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRoundKey:    round_key_q <= cfg_data_i[KeyW-1:0];
        CfgSboxInverse: sbox_q      <= cfg_data_i[SboxN*NibbleW-1:0];
        CfgPermInverse: perm_q      <= cfg_data_i[PermN*PosW-1:0];
        default:        ;
      endcase
    end
  end

  assign out_load       = !out_valid_q || plain_o.ready;
  assign in_load        = !in_valid_q || out_load;
  assign cipher_i.ready = in_load;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= cipher_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && cipher_i.valid) begin
      in_byte_q <= cipher_i.cipher_byte;
    end
  end

  // whitening, then rounds with key bytes 2, 1, 0
  assign round_data[0] = in_byte_q ^ round_key_q[KeyW-1 -: ByteW];

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    spn_dec_round u_round (
      .data_i (round_data[r]),
      .sbox_i (sbox_q),
      .perm_i (perm_q),
      .key_i  (round_key_q[(Rounds-1-r)*ByteW +: ByteW]),
      .data_o (round_data[r+1])
    );
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      out_byte_q <= round_data[Rounds];
    end
  end

  assign plain_o.valid      = out_valid_q;
  assign plain_o.plain_byte = out_byte_q;

endmodule

### test/spn_dec_plain_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn_dec_plain_checker
// Watches the cipher, plain and configuration ports of the SPN byte decipher
// ----------------------------------------------------------------------------
// Keeps its own copy of the key, inverse S-box and inverse permutation, taken
// from the configuration writes it sees. Each accepted ciphertext byte is
// deciphered here and queued. Each accepted plaintext byte is compared with
// the oldest queued byte. Mismatches and unexpected bytes are counted; the
// number of bytes still owed is reported to the testbench top.
// ----------------------------------------------------------------------------
module spn_dec_plain_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spn_dec_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spn_dec_pkg::CfgDataW-1:0] cfg_data_i,
  spn_dec_cipher_if                        cipher_i,
  spn_dec_plain_if                         plain_i,
  output int                               mismatch_cnt_o,
  output int                               pending_o
);
  import spn_dec_pkg::*;

  key_t  key_q;
  sbox_t sbox_q;
  perm_t perm_q;
  byte_t plain_expect_q[$];

  function automatic byte_t decipher_byte(byte_t c);
    byte_t m;
    byte_t p;
    m = c ^ key_q[31:24];
    for (int r = Rounds - 1; r >= 0; r--) begin
      for (int i = 0; i < PermN; i++) begin
        p[7-i] = m[7 - int'(perm_q[i])];
      end
      m = {sbox_q[p[7:4]], sbox_q[p[3:0]]};
      m = m ^ key_q[8*r +: 8];
    end
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    byte_t want;
    if (!rst_ni) begin
      key_q          = KeyRst;
      sbox_q         = SboxRst;
      perm_q         = PermRst;
      mismatch_cnt_o = 0;
      pending_o      = 0;
      plain_expect_q.delete();
    end else begin
      if (plain_i.valid === 1'b1 && plain_i.ready === 1'b1) begin
        if (plain_expect_q.size() == 0) begin
          $display("%0t: unexpected plain_byte %02h, expected nothing",
                   $time, plain_i.plain_byte);
          mismatch_cnt_o++;
        end else begin
          want = plain_expect_q.pop_front();
          if (plain_i.plain_byte !== want) begin
            $display("%0t: plain_byte expected %02h actual %02h",
                     $time, want, plain_i.plain_byte);
            mismatch_cnt_o++;
          end
        end
      end
      if (cipher_i.valid === 1'b1 && cipher_i.ready === 1'b1) begin
        plain_expect_q.push_back(decipher_byte(cipher_i.cipher_byte));
      end
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          CfgRoundKey:    key_q  = cfg_data_i[KeyW-1:0];
          CfgSboxInverse: sbox_q = cfg_data_i[SboxN*NibbleW-1:0];
          CfgPermInverse: perm_q = cfg_data_i[PermN*PosW-1:0];
          default: ;
        endcase
      end
      pending_o = plain_expect_q.size();
    end
  end

endmodule

### test/toy_spn_byte_decipher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_spn_byte_decipher_top_tb
// Stimulus and verdict for the toy SPN byte decipher
// ----------------------------------------------------------------------------
// Drives ciphertext bytes and table/key writes, stalls the plaintext side at
// random and once in a while for a long stretch, and lets the checker beside
// the block predict and compare every plaintext byte. A short directed part
// covers corner bytes and extreme or non-bijective tables, then randomized
// phases each load a new key and tables and stream bytes through.
// ----------------------------------------------------------------------------
module toy_spn_byte_decipher_top_tb;
  import spn_dec_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int unsigned        CycleLimit  = 200000;
  localparam int unsigned        RandBytes   = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  mismatch_cnt;
  int                  pending;
  int unsigned         cycle_cnt;
  bit                  tx_idle;
  bit                  rx_idle;
  int unsigned         rx_cnt;

  spn_dec_cipher_if cipher_if ();
  spn_dec_plain_if  plain_if ();

  toy_spn_byte_decipher_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cipher_i   (cipher_if),
    .plain_o    (plain_if)
  );

  spn_dec_plain_checker plain_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cipher_i       (cipher_if),
    .plain_i        (plain_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL toy_spn_byte_decipher_top");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_cipher(input byte_t c);
    int gap;
    gap = tx_idle ? $urandom_range(3) : 0;
    repeat (gap) begin
      cipher_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cipher_if.valid       <= 1'b1;
    cipher_if.cipher_byte <= c;
    do @(posedge clk_i); while (cipher_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic set_tables(input key_t k, input sbox_t s, input perm_t p,
                            input bit spare_wr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgRoundKey;
    cfg_data_i <= {32'($urandom), k};
    @(negedge clk_i);
    cfg_idx_i  <= CfgSboxInverse;
    cfg_data_i <= s;
    @(negedge clk_i);
    cfg_idx_i  <= CfgPermInverse;
    cfg_data_i <= {8'($urandom), 32'($urandom), p};
    @(negedge clk_i);
    if (spare_wr) begin
      cfg_idx_i  <= CfgIdxSpare;
      cfg_data_i <= {32'($urandom), 32'($urandom)};
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic finish_phase();
    cipher_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // plaintext side: random stalls plus a long hold now and then
  initial begin
    int w;
    plain_if.ready = 1'b0;
    rx_cnt         = 0;
    rx_idle        = 1'b1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      w = rx_idle ? $urandom_range(3) : 0;
      if (rx_cnt % 500 == 250) w = 80;
      repeat (w) begin
        plain_if.ready <= 1'b0;
        @(negedge clk_i);
      end
      plain_if.ready <= 1'b1;
      do @(posedge clk_i); while (plain_if.valid !== 1'b1);
      rx_cnt++;
      if (rx_cnt % 150 == 0) rx_idle = 1'($urandom_range(1));
      @(negedge clk_i);
    end
  end

  initial begin
    byte_t       corner_bytes[8];
    key_t        key;
    sbox_t       sbox;
    perm_t       perm;
    logic [3:0]  nib_tmp;
    logic [2:0]  pos_tmp;
    int unsigned j;
    int unsigned kind;
    int unsigned n;
    int unsigned sent;

    corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    tx_idle               = 1'b1;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CfgRoundKey;
    cfg_data_i            = '0;
    cipher_if.valid       = 1'b0;
    cipher_if.cipher_byte = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset tables and key
    foreach (corner_bytes[i]) send_cipher(corner_bytes[i]);
    finish_phase();

    // all-zero tables: every bit from the msb, every nibble to zero
    set_tables('1, '0, '0, 1'b0);
    send_cipher(8'h00);
    send_cipher(8'hFF);
    send_cipher(8'h5A);
    finish_phase();

    // all-ones tables, plus a write to the unused index that must be ignored
    set_tables('0, '1, '1, 1'b1);
    send_cipher(8'h00);
    send_cipher(8'hFF);
    send_cipher(8'hA5);
    finish_phase();

    // bit-reversing permutation and reversed s-box
    set_tables(32'h8001_FE7F, 64'h0123_4567_89AB_CDEF, 24'h05_3977, 1'b0);
    send_cipher(8'h01);
    send_cipher(8'h80);
    send_cipher(8'h0F);
    send_cipher(8'hF0);
    finish_phase();

    sent = 0;
    while (sent < RandBytes) begin
      kind = $urandom_range(9);
      key  = $urandom;
      if (kind == 0) key = '0;
      if (kind == 1) key = '1;
      if (kind < 7) begin
        for (int z = 0; z < SboxN; z++) sbox[z] = NibbleW'(z);
        for (int z = SboxN - 1; z > 0; z--) begin
          j       = $urandom_range(z);
          nib_tmp = sbox[z];
          sbox[z] = sbox[j];
          sbox[j] = nib_tmp;
        end
        for (int z = 0; z < PermN; z++) perm[z] = PosW'(z);
        for (int z = PermN - 1; z > 0; z--) begin
          j       = $urandom_range(z);
          pos_tmp = perm[z];
          perm[z] = perm[j];
          perm[j] = pos_tmp;
        end
      end else begin
        sbox = {32'($urandom), 32'($urandom)};
        perm = 24'($urandom);
      end
      set_tables(key, sbox, perm, $urandom_range(3) == 0);
      tx_idle = $urandom_range(2) != 0;
      n = $urandom_range(100, 300);
      repeat (n) send_cipher(8'($urandom_range(255)));
      sent += n;
      finish_phase();
    end

    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("PASS toy_spn_byte_decipher_top");
    end else begin
      $display("FAIL toy_spn_byte_decipher_top");
    end
    $finish;
  end

endmodule
